/* hw/rtl/wblc_pkg.sv */
// wblc_pkg: shared types, codes and helpers for the write-back block cache
// no dependencies
`default_nettype none
package wblc_pkg;
   localparam int unsigned SLOTS_DEF = 16;

   localparam logic [2:0] CMD_READ   = 3'd0;
   localparam logic [2:0] CMD_WRITE  = 3'd1;
   localparam logic [2:0] CMD_FILL   = 3'd2;
   localparam logic [2:0] CMD_COMMIT = 3'd3;
   localparam logic [2:0] CMD_TOSS   = 3'd4;

   localparam logic [2:0] KIND_READ = 3'd0;
   localparam logic [2:0] KIND_DONE = 3'd1;
   localparam logic [2:0] KIND_ERR  = 3'd2;
   localparam logic [2:0] KIND_WB   = 3'd3;
   localparam logic [2:0] KIND_FREQ = 3'd4;

   localparam logic [0:0] REG_BLOCK_SIZE   = 1'd0;
   localparam logic [0:0] REG_HEADER_BYTES = 1'd1;

   typedef struct packed {
      logic [31:0] tag;
      logic        dirty;
      logic [63:0] data;
   } entry_type;

   // per-cycle command to every cell of the chain
   typedef struct packed {
      logic        shift;     // take entry from left neighbor if at or left of hit
      logic        hit_valid; // a hit position bounds the shift
      logic        clr_dirty; // clear every dirty mark
      logic        clr_all;   // empty every cell
      logic        upd;       // overwrite the selected cell in place
      entry_type   upd_entry;
   } chain_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_EXEC, ST_COMMIT, ST_OUT
   } state_type;

   function automatic logic [63:0] size_mask(input logic [3:0] size);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         if (size > 4'(b)) m[b*8 +: 8] = 8'hff;
      end
      return m;
   endfunction
endpackage
`default_nettype wire

/* hw/rtl/wblc_if.sv */
// wblc_if: valid/ready channel interfaces for requests, responses and csr writes
// depends on nothing
`default_nettype none
interface wblc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [31:0] block_index;
   logic [63:0] payload;
   logic [7:0]  req_size;
   logic        fill_error;
   modport source (output valid, cmd, block_index, payload, req_size, fill_error,
                   input ready);
   modport sink   (input valid, cmd, block_index, payload, req_size, fill_error,
                   output ready);
endinterface

interface wblc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] out_index;
   logic [63:0] out_data;
   logic        last;
   modport source (output valid, kind, out_index, out_data, last, input ready);
   modport sink   (input valid, kind, out_index, out_data, last, output ready);
endinterface

interface wblc_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] index;
   logic [3:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/write_back_lru_block_cache.sv */
// write_back_lru_block_cache: top level, control sequencer around the cell chain
// depends on wblc_pkg, wblc_if, wblc_cell
//
// channel  dir  handshake    payload
// req_     in   valid/ready  cmd, block_index, payload, req_size, fill_error
// rsp_     out  valid/ready  kind, out_index, out_data, last
// csr_     in   valid/ready  index, data
//
// one request at a time: accept, search (tags compared in every cell), execute,
// then each result goes out through the output register; the next request is
// accepted as the final result leaves.
// a hit or install shifts the chain toward the back up to the hit cell, with
// the front cell loaded from the sequencer; a read miss empties the victim
// cell in place and the fill shifts it out.
// commit does the header, then walks one cell per cycle while rsp_ does not stall.
// reset is synchronous and empties every cell; stalls on rsp_ hold the result.
`default_nettype none
module write_back_lru_block_cache #(
   parameter int unsigned SLOTS = wblc_pkg::SLOTS_DEF
) (
   input wire       clock,
   input wire       reset,
   wblc_req_if.sink   req,
   wblc_rsp_if.source rsp,
   wblc_csr_if.sink   csr
);
   import wblc_pkg::*;
   localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   state_type st_ff, st_in;
   logic [3:0]  bsize_ff, bsize_in, hbytes_ff, hbytes_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [31:0] idx_ff, idx_in;
   logic [63:0] pay_ff, pay_in;
   logic [7:0]  size_ff, size_in;
   logic        ferr_ff, ferr_in;
   logic        hv_ff, hv_in, hd_ff, hd_in, await_ff, await_in;
   logic [63:0] hw_ff, hw_in;
   logic [31:0] pend_ff, pend_in;
   logic        hit_ff, hit_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [IW:0]   walk_ff, walk_in;
   logic        hdr_done_ff, hdr_done_in;
   // pending result and a queued final result
   logic        ov_ff, ov_in, olast_ff, olast_in;
   logic [2:0]  okind_ff, okind_in;
   logic [31:0] oidx_ff, oidx_in;
   logic [63:0] odata_ff, odata_in;
   logic        qv_ff, qv_in;
   logic [2:0]  qkind_ff, qkind_in;
   logic [31:0] qidx_ff, qidx_in;
   logic [63:0] qdata_ff, qdata_in;

   chain_ctl_type ctl;
   entry_type     front;
   entry_type     ents [SLOTS];
   logic [SLOTS-1:0] match;

   // cell chain
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      wblc_cell u_cell (
         .clock, .reset,
         .ctl            (ctl),
         .at_or_left_hit (IW'(g) <= pos_ff),
         .is_hit         ((IW'(g) == pos_ff) && !ctl.shift),
         .left_entry     ((g == 0) ? front : ents[(g == 0) ? 0 : g-1]),
         .entry          (ents[g]),
         .key            (idx_ff),
         .match          (match[g])
      );
   end

   // hit encoder over the match vector of the registered cell entries
   logic          any_hit;
   logic [IW-1:0] hit_pos;
   always_comb begin
      any_hit = 1'b0;
      hit_pos = '0;
      for (int i = SLOTS-1; i >= 0; i--) begin
         if (match[i] && (ents[i].tag != 32'd0)) begin
            any_hit = 1'b1;
            hit_pos = IW'(i);
         end
      end
   end

   assign req.ready = (st_ff == ST_IDLE) && (!ov_ff || rsp.ready);
   assign csr.ready = 1'b1;
   assign rsp.valid = ov_ff;
   assign rsp.kind = okind_ff;
   assign rsp.out_index = oidx_ff;
   assign rsp.out_data = odata_ff;
   assign rsp.last = olast_ff;

   entry_type vict, hitent, walk_ent;
   logic [63:0] bmask, hmask, wv;
   logic [IW-1:0] walk_idx;
   always_comb begin
      vict = ents[SLOTS-1];
      hitent = ents[pos_ff];
      walk_idx = walk_ff[IW-1:0];
      walk_ent = ents[walk_idx];
      bmask = size_mask(bsize_ff);
      hmask = size_mask(hbytes_ff);
      wv = pay_ff & bmask;
   end

   // sequencer: next state, chain control and results
   always_comb begin
      st_in = st_ff;
      bsize_in = bsize_ff; hbytes_in = hbytes_ff;
      cmd_in = cmd_ff; idx_in = idx_ff; pay_in = pay_ff; size_in = size_ff;
      ferr_in = ferr_ff;
      hv_in = hv_ff; hd_in = hd_ff; hw_in = hw_ff; await_in = await_ff;
      pend_in = pend_ff; hit_in = hit_ff; pos_in = pos_ff; walk_in = walk_ff;
      hdr_done_in = hdr_done_ff;
      ov_in = ov_ff; olast_in = olast_ff; okind_in = okind_ff;
      oidx_in = oidx_ff; odata_in = odata_ff;
      qv_in = qv_ff; qkind_in = qkind_ff; qidx_in = qidx_ff; qdata_in = qdata_ff;
      ctl = '0;
      front = '0;

      if (csr.valid) begin
         if (csr.index == REG_BLOCK_SIZE) bsize_in = csr.data;
         else                             hbytes_in = csr.data;
      end
      if (ov_ff && rsp.ready) ov_in = 1'b0;

      case (st_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in = req.cmd; idx_in = req.block_index; pay_in = req.payload;
               size_in = req.req_size; ferr_in = req.fill_error;
               st_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            hit_in = any_hit;
            pos_in = any_hit ? hit_pos : IW'(SLOTS-1);
            st_in = ST_EXEC;
         end
         ST_EXEC: begin
            st_in = ST_OUT;
            qv_in = 1'b1; qidx_in = idx_ff; qdata_in = '0; qkind_in = KIND_ERR;
            if (cmd_ff == CMD_TOSS) begin
               ctl.clr_all = 1'b1;
               hv_in = 1'b0; hd_in = 1'b0; hw_in = '0; await_in = 1'b0; pend_in = '0;
               qkind_in = KIND_DONE;
            end else if (cmd_ff == CMD_FILL) begin
               if (await_ff) begin
                  await_in = 1'b0; pend_in = '0; qidx_in = pend_ff;
                  if (ferr_ff) begin
                     qkind_in = KIND_ERR;
                  end else if (pend_ff == 32'd0) begin
                     hw_in = pay_ff & hmask; hv_in = 1'b1; hd_in = 1'b0;
                     qkind_in = KIND_READ; qdata_in = pay_ff & hmask;
                  end else begin
                     // victim already empty: shift whole chain, install at front
                     ctl.shift = 1'b1; ctl.hit_valid = 1'b0;
                     front.tag = pend_ff; front.data = wv;
                     qkind_in = KIND_READ; qdata_in = wv;
                  end
               end
            end else if (cmd_ff > CMD_TOSS || await_ff) begin
               qkind_in = KIND_ERR;
            end else if (cmd_ff == CMD_COMMIT) begin
               qv_in = 1'b0; walk_in = '0; hdr_done_in = 1'b0;
               st_in = ST_COMMIT;
            end else if (idx_ff == 32'd0) begin
               if ({4'd0, hbytes_ff} != size_ff) qkind_in = KIND_ERR;
               else if (cmd_ff == CMD_READ) begin
                  if (hv_ff) begin
                     qkind_in = KIND_READ; qdata_in = hw_ff;
                  end else begin
                     await_in = 1'b1; pend_in = '0; qkind_in = KIND_FREQ;
                  end
               end else begin
                  if (!hv_ff || hw_ff != (pay_ff & hmask)) begin
                     hw_in = pay_ff & hmask; hd_in = 1'b1;
                  end
                  hv_in = 1'b1; qkind_in = KIND_DONE;
               end
            end else if ({4'd0, bsize_ff} != size_ff) begin
               qkind_in = KIND_ERR;
            end else begin
               // writeback of a dirty victim goes first
               if (!hit_ff && vict.tag != 32'd0 && vict.dirty) begin
                  ov_in = 1'b1; olast_in = 1'b0; okind_in = KIND_WB;
                  oidx_in = vict.tag; odata_in = vict.data;
               end
               if (cmd_ff == CMD_READ) begin
                  if (hit_ff) begin
                     ctl.shift = 1'b1; ctl.hit_valid = 1'b1;
                     front = hitent;
                     qkind_in = KIND_READ; qdata_in = hitent.data;
                  end else begin
                     // evict: empty the victim cell in place, the fill installs later
                     ctl.upd = 1'b1; ctl.upd_entry = '0;
                     await_in = 1'b1; pend_in = idx_ff; qkind_in = KIND_FREQ;
                  end
               end else begin
                  ctl.shift = 1'b1; ctl.hit_valid = 1'b1;
                  front.tag = idx_ff; front.data = wv;
                  front.dirty = hit_ff ? (hitent.dirty || hitent.data != wv) : 1'b1;
                  qkind_in = KIND_DONE;
               end
            end
         end
         ST_COMMIT: begin
            if (!ov_ff || rsp.ready) begin
               if (!hdr_done_ff) begin
                  hdr_done_in = 1'b1;
                  if (hv_ff && hd_ff) begin
                     ov_in = 1'b1; olast_in = 1'b0; okind_in = KIND_WB;
                     oidx_in = '0; odata_in = hw_ff; hd_in = 1'b0;
                  end
               end else if (walk_ff < (IW+1)'(SLOTS)) begin
                  walk_in = walk_ff + 1'b1;
                  if (walk_ent.tag != 32'd0 && walk_ent.dirty) begin
                     ov_in = 1'b1; olast_in = 1'b0; okind_in = KIND_WB;
                     oidx_in = walk_ent.tag; odata_in = walk_ent.data;
                  end
               end else begin
                  ctl.clr_dirty = 1'b1;
                  qv_in = 1'b1; qkind_in = KIND_DONE; qidx_in = idx_ff; qdata_in = '0;
                  st_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!ov_ff || rsp.ready) begin
               ov_in = 1'b1; olast_in = 1'b1; okind_in = qkind_ff;
               oidx_in = qidx_ff; odata_in = qdata_ff; qv_in = 1'b0;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; bsize_ff <= 4'd8; hbytes_ff <= 4'd8;
         hv_ff <= 1'b0; hd_ff <= 1'b0; hw_ff <= '0; await_ff <= 1'b0; pend_ff <= '0;
         ov_ff <= 1'b0; qv_ff <= 1'b0; hit_ff <= 1'b0; hdr_done_ff <= 1'b0;
      end else begin
         st_ff <= st_in; bsize_ff <= bsize_in; hbytes_ff <= hbytes_in;
         hv_ff <= hv_in; hd_ff <= hd_in; hw_ff <= hw_in; await_ff <= await_in;
         pend_ff <= pend_in; ov_ff <= ov_in; qv_ff <= qv_in; hit_ff <= hit_in;
         hdr_done_ff <= hdr_done_in;
      end
      cmd_ff <= cmd_in; idx_ff <= idx_in; pay_ff <= pay_in; size_ff <= size_in;
      ferr_ff <= ferr_in; pos_ff <= pos_in; walk_ff <= walk_in;
      olast_ff <= olast_in; okind_ff <= okind_in; oidx_ff <= oidx_in;
      odata_ff <= odata_in; qkind_ff <= qkind_in; qidx_ff <= qidx_in;
      qdata_ff <= qdata_in;
   end
endmodule
`default_nettype wire

/* hw/rtl/wblc_cell.sv */
// wblc_cell: one entry of the move-to-front chain, compares its tag locally
// depends on wblc_pkg
`default_nettype none
module wblc_cell (
   input  wire                      clock,
   input  wire                      reset,
   input  wire wblc_pkg::chain_ctl_type ctl,
   input  wire                      at_or_left_hit, // this cell lies at or before the hit
   input  wire                      is_hit,
   input  wire wblc_pkg::entry_type left_entry,
   output wblc_pkg::entry_type      entry,
   input  wire  [31:0]              key,
   output logic                     match
);
   import wblc_pkg::*;

   entry_type entry_ff, entry_in;

   assign entry = entry_ff;
   assign match = (entry_ff.tag == key);

   // shift toward the back up to the hit cell, or clear, or update in place
   always_comb begin
      entry_in = entry_ff;
      if (ctl.clr_all) begin
         entry_in = '0;
      end else if (ctl.clr_dirty) begin
         entry_in.dirty = 1'b0;
      end else if (ctl.shift && (!ctl.hit_valid || at_or_left_hit) && !is_hit) begin
         entry_in = left_entry;
      end else if (ctl.upd && is_hit) begin
         entry_in = ctl.upd_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) entry_ff <= '0;
      else       entry_ff <= entry_in;
   end
endmodule
`default_nettype wire
